/* rtl/rmpc_pkg.sv */
// Shared types, constants and preset tables for the ramped motor PWM commander.
`timescale 1ns / 1ps
package rmpc_pkg;

    // Block dimensions.
    localparam int NUM_MOTORS    = 7;
    localparam int NUM_ACTUATORS = 2;
    localparam int PRESET_COUNT  = 7;

    localparam int DUTY_W    = 8;
    localparam int CHAN_W    = 4;
    localparam int INSTR_W   = 9;
    localparam int CFG_IDX_W = 3;
    localparam int DATA_W    = 16;

    localparam int MIDX_W   = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
    localparam int AIDX_W   = (NUM_ACTUATORS > 1) ? $clog2(NUM_ACTUATORS) : 1;
    localparam int PIN_W    = $clog2(2 * NUM_ACTUATORS);
    localparam int PRESET_W = 3;

    // Command queue between the decoder and the sequencer.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FWD_BASE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REV_BASE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ACT_DUTY = 3'd5;

    // Configuration reset values.
    localparam logic [DUTY_W-1:0] RST_NEUTRAL  = 8'd100;
    localparam logic [DUTY_W-1:0] RST_UPPER    = 8'd198;
    localparam logic [DUTY_W-1:0] RST_LOWER    = 8'd192;
    localparam logic [DUTY_W-1:0] RST_FWD_BASE = 8'd200;
    localparam logic [DUTY_W-1:0] RST_REV_BASE = 8'd188;
    localparam logic [DUTY_W-1:0] RST_ACT_DUTY = 8'd130;

    // Instruction code boundaries.
    localparam logic [DUTY_W-1:0] CODE_STOP      = 8'd0;
    localparam logic [DUTY_W-1:0] CODE_DIR_LO    = 8'd1;
    localparam logic [DUTY_W-1:0] CODE_DIR_HI    = 8'd4;
    localparam logic [DUTY_W-1:0] CODE_PRESET_LO = 8'd5;
    localparam logic [DUTY_W-1:0] CODE_PRESET_HI = 8'd14;
    localparam logic [DUTY_W-1:0] CODE_ACT_LO    = 8'd15;
    localparam logic [DUTY_W-1:0] CODE_ACT_HI    = 8'd18;
    localparam logic [DUTY_W-1:0] CODE_DRIVE_OFS = 8'd100;

    // Drive direction codes.
    localparam logic [2:0] DIR_NONE  = 3'd0;
    localparam logic [2:0] DIR_FWD   = 3'd1;
    localparam logic [2:0] DIR_BACK  = 3'd2;
    localparam logic [2:0] DIR_RIGHT = 3'd3;
    localparam logic [2:0] DIR_LEFT  = 3'd4;

    // Operation kinds passed from the decoder to the sequencer.
    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_STOP   = 3'd1,
        OP_DIR    = 3'd2,
        OP_PRESET = 3'd3,
        OP_ACT    = 3'd4,
        OP_DRIVE  = 3'd5
    } op_kind_t;

    // One decoded operation.
    typedef struct packed {
        op_kind_t            kind;
        logic [MIDX_W-1:0]   motor;
        logic [AIDX_W-1:0]   act;
        logic                flag;
        logic [DUTY_W-1:0]   val;
    } op_t;

    // Configuration register file contents.
    typedef struct packed {
        logic [DUTY_W-1:0] neutral;
        logic [DUTY_W-1:0] upper;
        logic [DUTY_W-1:0] lower;
        logic [DUTY_W-1:0] fwd_base;
        logic [DUTY_W-1:0] rev_base;
        logic [DUTY_W-1:0] act_duty;
    } cfg_t;

    // Forward preset target per motor.
    function automatic logic [DUTY_W-1:0] preset_fwd(input logic [PRESET_W-1:0] idx);
        logic [DUTY_W-1:0] r;
        case (idx)
            3'd0:    r = 8'd170;
            3'd1:    r = 8'd170;
            3'd2:    r = 8'd160;
            3'd3:    r = 8'd160;
            3'd4:    r = 8'd188;
            3'd5:    r = 8'd188;
            3'd6:    r = 8'd185;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    // Backward preset target per motor.
    function automatic logic [DUTY_W-1:0] preset_bwd(input logic [PRESET_W-1:0] idx);
        logic [DUTY_W-1:0] r;
        case (idx)
            3'd0:    r = 8'd215;
            3'd1:    r = 8'd215;
            3'd2:    r = 8'd220;
            3'd3:    r = 8'd220;
            3'd4:    r = 8'd200;
            3'd5:    r = 8'd200;
            3'd6:    r = 8'd203;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

endpackage

/* rtl/rmpc_front.sv */
// Input side: accepts words, decodes instruction codes and queues operations.
`timescale 1ns / 1ps
module rmpc_front (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rmpc_pkg::DATA_W-1:0]   s_tdata,
    input  logic                          s_tuser,
    input  logic                          q_full,
    output logic                          q_push,
    output rmpc_pkg::op_t                 q_op
);
    import rmpc_pkg::*;

    logic                code_neg;
    logic [DUTY_W-1:0]   code;
    logic [3:0]          pre_d;
    logic [3:0]          pre_m;
    logic [1:0]          act_d;
    logic                keep;

    // Words are taken whenever the queue has room.
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full && keep;

    assign code_neg = s_tdata[INSTR_W-1];
    assign code     = s_tdata[DUTY_W-1:0];
    assign pre_d    = 4'(code - CODE_PRESET_LO);
    assign pre_m    = 4'(pre_d[3:1]) + 4'd2;
    assign act_d    = 2'(code - CODE_ACT_LO);

    // Classify the word; codes that change nothing are dropped here.
    always_comb
    begin
        q_op       = '0;
        q_op.kind  = OP_TICK;
        keep       = 1'b0;
        if (s_tuser)
        begin
            keep = 1'b1;
        end
        else if (!code_neg)
        begin
            if (code == CODE_STOP)
            begin
                q_op.kind = OP_STOP;
                keep      = 1'b1;
            end
            else if (code inside {[CODE_DIR_LO:CODE_DIR_HI]})
            begin
                q_op.kind = OP_DIR;
                q_op.val  = code;
                keep      = 1'b1;
            end
            else if (code inside {[CODE_PRESET_LO:CODE_PRESET_HI]})
            begin
                q_op.kind  = OP_PRESET;
                q_op.motor = MIDX_W'(pre_m);
                q_op.flag  = pre_d[0];
                q_op.val   = pre_d[0] ? preset_fwd(pre_m[PRESET_W-1:0])
                                      : preset_bwd(pre_m[PRESET_W-1:0]);
                keep       = (int'(pre_m) < NUM_MOTORS) && (int'(pre_m) < PRESET_COUNT);
            end
            else if (code inside {[CODE_ACT_LO:CODE_ACT_HI]})
            begin
                q_op.kind = OP_ACT;
                q_op.act  = AIDX_W'(act_d[1]);
                q_op.flag = act_d[0];
                keep      = int'(act_d[1]) < NUM_ACTUATORS;
            end
            else if (code > CODE_DRIVE_OFS)
            begin
                q_op.kind = OP_DRIVE;
                q_op.val  = code - CODE_DRIVE_OFS;
                keep      = 1'b1;
            end
        end
    end

endmodule

/* rtl/rmpc_queue.sv */
// Short operation queue between the decoder and the sequencer.
`timescale 1ns / 1ps
module rmpc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rmpc_pkg::op_t   push_op,
    output logic            full,
    input  logic            pop,
    output logic            valid,
    output rmpc_pkg::op_t   head_op
);
    import rmpc_pkg::*;

    op_t [QDEPTH-1:0]    slot_reg;
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign full    = count_reg == QCNT_W'(QDEPTH);
    assign valid   = count_reg != '0;
    assign head_op = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // Occupancy bookkeeping.
    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

/* rtl/rmpc_back.sv */
// Sequencer: executes queued operations, ramps motor duties and emits channel writes.
`timescale 1ns / 1ps
module rmpc_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rmpc_pkg::cfg_t                cfg,
    input  logic                          q_valid,
    input  rmpc_pkg::op_t                 q_op,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rmpc_pkg::DATA_W-1:0]   m_tdata,
    output logic                          m_tlast
);
    import rmpc_pkg::*;

    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_STOP = 5'b00010,
        B_ACT  = 5'b00100,
        B_TICK = 5'b01000,
        B_SNAP = 5'b10000
    } bstate_t;

    bstate_t                               state_reg, state_next;
    logic [NUM_MOTORS-1:0][DUTY_W-1:0]     duty_reg, duty_next;
    logic [NUM_MOTORS-1:0][DUTY_W-1:0]     tgt_reg, tgt_next;
    logic [2:0]                            dir_reg, dir_next;
    logic [NUM_MOTORS-1:0]                 mask_reg, mask_next;
    logic [MIDX_W-1:0]                     idx_reg, idx_next;
    logic [PIN_W-1:0]                      cnt_reg, cnt_next;
    logic [AIDX_W-1:0]                     act_reg, act_next;
    logic                                  odd_reg, odd_next;
    logic                                  pin_reg, pin_next;

    logic                  out_valid_reg;
    logic [CHAN_W-1:0]     out_chan_reg;
    logic [DUTY_W-1:0]     out_duty_reg;
    logic                  out_last_reg;

    logic                  can_emit;
    logic                  emit;
    logic [CHAN_W-1:0]     e_chan;
    logic [DUTY_W-1:0]     e_duty;
    logic                  e_last;

    logic [NUM_MOTORS-1:0] tick_mask;
    logic [NUM_MOTORS-1:0] rem_mask;

    // Ramp datapath signals.
    logic [DUTY_W-1:0]     cur;
    logic [DUTY_W-1:0]     tg;
    logic [DUTY_W-1:0]     v0;
    logic [DUTY_W-1:0]     du;
    logic [DUTY_W-1:0]     dl;
    logic [DUTY_W-1:0]     step_u;
    logic [DUTY_W-1:0]     step_l;
    logic [DUTY_W-1:0]     tt;
    logic [DUTY_W:0]       sum;
    logic [DUTY_W-1:0]     res;
    logic                  snap;

    // Drive target signals.
    logic [DUTY_W:0]       fwd_sum;
    logic [DUTY_W-1:0]     fwd_tgt;
    logic [DUTY_W-1:0]     rev_tgt;
    logic                  f0;
    logic                  f1;

    assign can_emit = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(DATA_W - CHAN_W - DUTY_W){1'b0}}, out_duty_reg, out_chan_reg};

    // Motors off target at the start of a tick, and the ones still left after this motor.
    always_comb
    begin
        for (int i = 0; i < NUM_MOTORS; i++)
        begin
            tick_mask[i] = duty_reg[i] != tgt_reg[i];
            rem_mask[i]  = mask_reg[i] && (MIDX_W'(i) != idx_reg);
        end
    end

    // One ramp step for the selected motor.
    always_comb
    begin
        cur = duty_reg[idx_reg];
        tg  = tgt_reg[idx_reg];
        if (cur == cfg.neutral)
        begin
            v0 = (tg >= cfg.fwd_base) ? cfg.upper : cfg.lower;
        end
        else
        begin
            v0 = cur;
        end
        du     = v0 - cfg.upper;
        step_u = ((du >> 1) == '0) ? DUTY_W'(1) : (du >> 1);
        dl     = cfg.lower - v0;
        if (cfg.lower > v0 && (dl >> 1) != '0)
        begin
            step_l = dl >> 1;
        end
        else
        begin
            step_l = DUTY_W'(1);
        end
        tt  = tg;
        sum = '0;
        res = tg;
        if (v0 >= cfg.upper && tg < v0)
        begin
            // Above the forward edge, heading down.
            tt  = (tg == cfg.neutral) ? cfg.upper : tg;
            sum = {1'b0, step_u} + {1'b0, tt};
            res = ({1'b0, v0} < sum) ? tt : v0 - step_u;
        end
        else if (v0 >= cfg.upper && tg > v0)
        begin
            // Above the forward edge, heading up.
            sum = {1'b0, v0} + {1'b0, step_u};
            res = (sum > {1'b0, tg}) ? tg : sum[DUTY_W-1:0];
        end
        else if (tg < v0 && tg != cfg.neutral)
        begin
            // Reverse side, heading down.
            sum = {1'b0, step_l} + {1'b0, tg};
            res = ({1'b0, v0} < sum) ? tg : v0 - step_l;
        end
        else
        begin
            // Reverse side heading up, or returning toward the lower edge.
            tt  = (tg == cfg.neutral) ? cfg.lower : tg;
            sum = {1'b0, v0} + {1'b0, step_l};
            res = (sum > {1'b0, tt}) ? tt : sum[DUTY_W-1:0];
        end
        snap = (res == cfg.upper) || (res == cfg.lower);
    end

    // Drive wheel targets for a speed command.
    always_comb
    begin
        fwd_sum = {1'b0, cfg.fwd_base} + {1'b0, q_op.val};
        fwd_tgt = fwd_sum[DUTY_W] ? {DUTY_W{1'b1}} : fwd_sum[DUTY_W-1:0];
        rev_tgt = (cfg.rev_base < q_op.val) ? '0 : cfg.rev_base - q_op.val;
        f0 = (dir_reg == DIR_NONE) || (dir_reg == DIR_FWD) || (dir_reg == DIR_RIGHT);
        f1 = (dir_reg == DIR_NONE) || (dir_reg == DIR_FWD) || (dir_reg == DIR_LEFT);
    end

    // Sequencer control.
    always_comb
    begin
        state_next = state_reg;
        duty_next  = duty_reg;
        tgt_next   = tgt_reg;
        dir_next   = dir_reg;
        mask_next  = mask_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        act_next   = act_reg;
        odd_next   = odd_reg;
        pin_next   = pin_reg;
        q_pop      = 1'b0;
        emit       = 1'b0;
        e_chan     = '0;
        e_duty     = '0;
        e_last     = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    case (q_op.kind)
                        OP_TICK:
                        begin
                            mask_next = tick_mask;
                            idx_next  = '0;
                            if (tick_mask != '0)
                            begin
                                state_next = B_TICK;
                            end
                        end
                        OP_STOP:
                        begin
                            dir_next = DIR_NONE;
                            for (int i = 0; i < NUM_MOTORS; i++)
                            begin
                                tgt_next[i] = cfg.neutral;
                            end
                            cnt_next   = '0;
                            state_next = B_STOP;
                        end
                        OP_DIR:
                        begin
                            dir_next = q_op.val[2:0];
                        end
                        OP_PRESET:
                        begin
                            tgt_next[q_op.motor] = q_op.val;
                        end
                        OP_ACT:
                        begin
                            act_next   = q_op.act;
                            odd_next   = q_op.flag;
                            pin_next   = 1'b0;
                            state_next = B_ACT;
                        end
                        OP_DRIVE:
                        begin
                            tgt_next[0] = f0 ? fwd_tgt : rev_tgt;
                            tgt_next[1] = f1 ? fwd_tgt : rev_tgt;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            B_STOP:
            begin
                // Clear every actuator pin in order.
                if (can_emit)
                begin
                    emit     = 1'b1;
                    e_chan   = CHAN_W'(NUM_MOTORS) + CHAN_W'(cnt_reg);
                    e_duty   = '0;
                    e_last   = cnt_reg == PIN_W'(2 * NUM_ACTUATORS - 1);
                    cnt_next = cnt_reg + 1'b1;
                    if (e_last)
                    begin
                        state_next = B_IDLE;
                    end
                end
            end
            B_ACT:
            begin
                // Drive one pin of the pair, then the other.
                if (can_emit)
                begin
                    emit   = 1'b1;
                    e_chan = CHAN_W'(NUM_MOTORS + 2 * int'(act_reg) + int'(pin_reg));
                    e_duty = (odd_reg ^ pin_reg) ? cfg.act_duty : '0;
                    e_last = pin_reg;
                    pin_next = 1'b1;
                    if (pin_reg)
                    begin
                        state_next = B_IDLE;
                    end
                end
            end
            B_TICK:
            begin
                if (!mask_reg[idx_reg])
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else if (can_emit)
                begin
                    emit   = 1'b1;
                    e_chan = CHAN_W'(idx_reg);
                    e_duty = res;
                    e_last = !snap && (rem_mask == '0);
                    if (snap)
                    begin
                        state_next = B_SNAP;
                    end
                    else
                    begin
                        duty_next[idx_reg] = res;
                        mask_next          = rem_mask;
                        idx_next           = idx_reg + 1'b1;
                        if (rem_mask == '0)
                        begin
                            state_next = B_IDLE;
                        end
                    end
                end
            end
            B_SNAP:
            begin
                // Duty landed on a deadband edge: fall back to neutral.
                if (can_emit)
                begin
                    emit               = 1'b1;
                    e_chan             = CHAN_W'(idx_reg);
                    e_duty             = cfg.neutral;
                    e_last             = rem_mask == '0;
                    duty_next[idx_reg] = cfg.neutral;
                    mask_next          = rem_mask;
                    idx_next           = idx_reg + 1'b1;
                    state_next         = (rem_mask == '0) ? B_IDLE : B_TICK;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Sequencer and motor state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            duty_reg      <= {NUM_MOTORS{RST_NEUTRAL}};
            tgt_reg       <= {NUM_MOTORS{RST_NEUTRAL}};
            dir_reg       <= DIR_NONE;
            mask_reg      <= '0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            act_reg       <= '0;
            odd_reg       <= 1'b0;
            pin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            duty_reg  <= duty_next;
            tgt_reg   <= tgt_next;
            dir_reg   <= dir_next;
            mask_reg  <= mask_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            act_reg   <= act_next;
            odd_reg   <= odd_next;
            pin_reg   <= pin_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output word register.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_chan_reg <= e_chan;
            out_duty_reg <= e_duty;
            out_last_reg <= e_last;
        end
    end

endmodule

/* rtl/ramped_motor_pwm_commander.sv */
// Top level of the ramped motor PWM commander: configuration registers and the two halves.
`timescale 1ns / 1ps
//
// The block takes command words on the s_ stream and returns channel writes on the m_ stream.
// An input word with s_tuser low carries a robot instruction code in s_tdata; with s_tuser
// high it is a ramp tick that moves every motor that is off target by one step. Each output
// word names a channel (motors first, then the actuator pins) and the duty written to it;
// m_tlast marks the final write caused by one input word. Words that cause no write
// produce nothing on the output.
// Input words are decoded on acceptance and held in a four-entry queue, so s_tready stays
// high while the queue has room, also while an output word waits on m_tready. The sequencer
// takes one operation per cycle when idle. A stop emits one write per cycle for each actuator
// pin, an actuator code two writes, and a tick visits one motor per cycle plus a further
// write of neutral for each snap, all only while the output is not stalled.
// With the queue empty and the sequencer idle, an accepted word passes through the queue
// slot and the sequencer state before its first write is registered onto m_tvalid; a tick
// also passes over each on-target motor ahead of the first motor it moves.
// When m_tready is low the sequencer holds its place and the output word stays put. Reset
// (rst_n low) sets the configuration registers to their defaults, every duty and target to
// neutral, the drive direction to none, and empties the queue. The user writes configuration
// via cfg_we / cfg_index / cfg_wdata only while the block is idle; the block never checks.
module ramped_motor_pwm_commander (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration write port.
    input  logic                             cfg_we,
    input  logic [rmpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rmpc_pkg::DUTY_W-1:0]      cfg_wdata,
    // Command stream.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rmpc_pkg::DATA_W-1:0]      s_tdata,   // [8:0] instruction, zero padding
    input  logic                             s_tuser,   // [0] cmd (1 = ramp tick)
    // Channel write stream.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rmpc_pkg::DATA_W-1:0]      m_tdata,   // [3:0] channel, [11:4] duty, zeros
    output logic                             m_tlast
);
    import rmpc_pkg::*;

    cfg_t   cfg_reg;
    logic   q_push;
    op_t    q_in_op;
    logic   q_full;
    logic   q_pop;
    logic   q_valid;
    op_t    q_head_op;

    // Configuration register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.neutral  <= RST_NEUTRAL;
            cfg_reg.upper    <= RST_UPPER;
            cfg_reg.lower    <= RST_LOWER;
            cfg_reg.fwd_base <= RST_FWD_BASE;
            cfg_reg.rev_base <= RST_REV_BASE;
            cfg_reg.act_duty <= RST_ACT_DUTY;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NEUTRAL:  cfg_reg.neutral  <= cfg_wdata;
                REG_UPPER:    cfg_reg.upper    <= cfg_wdata;
                REG_LOWER:    cfg_reg.lower    <= cfg_wdata;
                REG_FWD_BASE: cfg_reg.fwd_base <= cfg_wdata;
                REG_REV_BASE: cfg_reg.rev_base <= cfg_wdata;
                REG_ACT_DUTY: cfg_reg.act_duty <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // Decoder.
    rmpc_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_op     (q_in_op)
    );

    // Operation queue.
    rmpc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (q_in_op),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .head_op (q_head_op)
    );

    // Sequencer.
    rmpc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_op     (q_head_op),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
